// ----- rtl/rld_pkg.sv -----
// Shared types and constants for the radial lens distortion remap block.
// Holds the fixed field widths, the Q24 polynomial coefficients and the sideband structs.
// Depends on nothing; every other file imports it.
package rld_pkg;

	// Field and internal widths that follow from the fixed port widths.
	localparam int DIM_W   = 13;
	localparam int PIX_X_W = 11;
	localparam int PIX_Y_W = 12;
	localparam int COL_W   = 12;
	localparam int IDX_W   = 2;
	localparam int CW      = 28;
	localparam int WK_W    = 44;
	localparam int SQ_W    = 56;
	localparam int NUM_W   = 57;
	localparam int DD_Q    = 35;
	localparam int DD_W    = 36;
	localparam int DD_INT  = 11;
	localparam int DD_FRAC = 24;
	localparam int C3_W    = 21;
	localparam int A_W     = 32;
	localparam int B_W     = 44;
	localparam int DQ_W    = 56;
	localparam int PSC_W   = CW + DQ_W;
	localparam int OFF_W   = 31;
	localparam int POS_W   = 31;
	localparam int TPOS_W  = 32;

	// Lens center factor 1.1453/4 in Q32 and the polynomial coefficients in Q24.
	localparam logic [30:0]     K_Q32     = 31'd1229756511;
	localparam logic [C3_W-1:0] COEF3_Q24 = 21'd1258291;
	localparam logic [23:0]     COEF2_Q24 = 24'd2097152;
	localparam logic [23:0]     COEF1_Q24 = 24'd5872026;
	localparam logic [DD_W-1:0] DD_SAT    = DD_W'(2048) << DD_FRAC;

	// Scaled offset limit: product plus rounding half above 2^54 saturates.
	localparam logic [PSC_W-1:0] SC_LIM   = (PSC_W'(1) << 54) + (PSC_W'(1) << 23);
	localparam logic [OFF_W-1:0] OFF_SAT  = OFF_W'(1) << 30;

	localparam logic [DIM_W-1:0] W_RESET  = 13'd1280;
	localparam logic [DIM_W-1:0] H_RESET  = 13'd800;

	typedef enum logic [IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic             xneg;
		logic [CW-1:0]    cx;
		logic [DIM_W-1:0] w;
		logic [COL_W-1:0] mirror;
	} xside_t;

	typedef struct packed {
		logic             yneg;
		logic [CW-1:0]    cy;
		logic [DIM_W-1:0] h;
	} yside_t;

	typedef struct packed {
		xside_t        xs;
		yside_t        ys;
		logic [CW-1:0] dxm;
		logic [CW-1:0] dym;
	} geo_t;

	typedef struct packed {
		geo_t g;
		logic sat;
	} ddside_t;

	typedef struct packed {
		geo_t            g;
		logic [DD_W-1:0] dd;
	} polyside_t;

	typedef struct packed {
		logic             zero;
		logic             sat;
		logic [COL_W-1:0] mirror;
	} uside_t;

	typedef struct packed {
		logic zero;
		logic sat;
	} vside_t;

endpackage

// ----- rtl/rld_mul.sv -----
// Two-stage multiply-add: four registered partial products, then one summing stage.
// Carries a valid bit and a sideband vector alongside. Uses rld_pkg only by convention.
module rld_mul
	import rld_pkg::*;
#(
	parameter int AW = 16,
	parameter int BW = 16,
	parameter int SW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             v_in,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	input  logic [AW+BW-1:0] c,
	input  logic [SW-1:0]    sb_in,
	output logic             v_out,
	output logic [AW+BW-1:0] p,
	output logic [SW-1:0]    sb_out
);

	localparam int AL = AW / 2;
	localparam int AH = AW - AL;
	localparam int BL = BW / 2;
	localparam int BH = BW - BL;
	localparam int PW = AW + BW;

	logic             v_s1, v_s2;
	logic [AL+BL-1:0] pll_s1;
	logic [AL+BH-1:0] plh_s1;
	logic [AH+BL-1:0] phl_s1;
	logic [AH+BH-1:0] phh_s1;
	logic [PW-1:0]    c_s1, p_s2;
	logic [SW-1:0]    sb_s1, sb_s2;

	// Valid bits move with the data whenever the pipeline advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	// Partial products first, their weighted sum with the addend next.
	always_ff @(posedge clk) begin
		if (en) begin
			pll_s1 <= a[AL-1:0] * b[BL-1:0];
			plh_s1 <= a[AL-1:0] * b[BW-1:BL];
			phl_s1 <= a[AW-1:AL] * b[BL-1:0];
			phh_s1 <= a[AW-1:AL] * b[BW-1:BL];
			c_s1   <= c;
			sb_s1  <= sb_in;
			p_s2   <= PW'(pll_s1) + (PW'(plh_s1) << BL) + (PW'(phl_s1) << AL)
				+ (PW'(phh_s1) << (AL + BL)) + c_s1;
			sb_s2  <= sb_s1;
		end
	end

	assign v_out  = v_s2;
	assign p      = p_s2;
	assign sb_out = sb_s2;

endmodule

// ----- rtl/rld_div.sv -----
// Pipelined restoring divider: one quotient bit per register stage.
// The caller supplies the starting remainder and the dividend bits still to be fed.
module rld_div
	import rld_pkg::*;
#(
	parameter int DW = 16,
	parameter int QN = 8,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  logic [DW-1:0] r_in,
	input  logic [QN-1:0] fb_in,
	input  logic [DW-1:0] d_in,
	input  logic [SW-1:0] sb_in,
	output logic          v_out,
	output logic [QN-1:0] q_out,
	output logic [SW-1:0] sb_out
);

	logic          v_s   [QN];
	logic [QN-1:0] quo_s [QN];
	logic [SW-1:0] sb_s  [QN];
	logic [DW-1:0] rem_s [QN-1];
	logic [DW-1:0] den_s [QN-1];
	logic [QN-1:0] fb_s  [QN-1];

	for (genvar k = 0; k < QN; k++) begin : g_step
		logic [DW-1:0] rem_i, den_i;
		logic [QN-1:0] quo_i, fb_i;
		logic [SW-1:0] sb_i;
		logic          v_i;
		logic [DW:0]   trial;
		logic          take;

		// Stage inputs come from the ports or from the stage before.
		if (k == 0) begin : g_first
			assign rem_i = r_in;
			assign den_i = d_in;
			assign quo_i = '0;
			assign fb_i  = fb_in;
			assign sb_i  = sb_in;
			assign v_i   = v_in;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign den_i = den_s[k-1];
			assign quo_i = quo_s[k-1];
			assign fb_i  = fb_s[k-1];
			assign sb_i  = sb_s[k-1];
			assign v_i   = v_s[k-1];
		end

		// Shift in the next dividend bit and subtract the divisor if it fits.
		assign trial = {rem_i, fb_i[QN-1]};
		assign take  = (trial >= {1'b0, den_i});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= {quo_i[QN-2:0], take};
				sb_s[k]  <= sb_i;
			end
		end

		// The last stage keeps only the quotient.
		if (k < QN - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= take ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];
					den_s[k] <= den_i;
					fb_s[k]  <= fb_i << 1;
				end
			end
		end
	end

	assign v_out  = v_s[QN-1];
	assign q_out  = quo_s[QN-1];
	assign sb_out = sb_s[QN-1];

endmodule

// ----- rtl/radial_lens_distortion_map_core.sv -----
// Top level of the radial lens distortion remap pipeline.
// Depends on rld_pkg, rld_mul and rld_div.
//
// Usage:
//   The input channel (in_valid, in_stall, pixel_x, pixel_y) takes one pixel
//   of the left half of a side-by-side stereo frame per beat. The output
//   channel (out_valid, out_stall, left_tex_u, right_tex_u, tex_v,
//   mirror_column) returns one remap entry per input beat, in order.
//   frame_width and frame_height are written through write_en, reg_index and
//   write_data while the pipeline is empty; other indexes are ignored.
//   Throughput is one beat per cycle while the output is not stalled. The
//   pipeline runs through the 35-stage divider that normalizes the
//   squared radius, the three Q24 polynomial multiplies, the offset scaling
//   multiply and the FRAC_BITS+1 stage dividers that form u and v.
//   While out_valid is high and out_stall is asserted, the whole pipeline
//   holds and in_stall is raised; nothing is dropped or repeated.
//   Reset clears all valid bits and returns the frame size to 1280 by 800.
module radial_lens_distortion_map_core
	import rld_pkg::*;
#(
	parameter int MAX_DIM   = 4096,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 write_en,
	input  logic [IDX_W-1:0]     reg_index,
	input  logic [DIM_W-1:0]     write_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PIX_X_W-1:0]   pixel_x,
	input  logic [PIX_Y_W-1:0]   pixel_y,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [FRAC_BITS-1:0] left_tex_u,
	output logic [FRAC_BITS:0]   right_tex_u,
	output logic [FRAC_BITS:0]   tex_v,
	output logic [COL_W-1:0]     mirror_column
);

	localparam int F    = FRAC_BITS;
	localparam int TD_W = DIM_W + 16;
	localparam int NT_W = POS_W + F + 1;
	localparam int QT   = F + 1;

	// Configuration registers.
	logic [DIM_W-1:0] fw_q, fh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= W_RESET;
			fh_q <= H_RESET;
		end else if (write_en) begin
			unique case (reg_idx_t'(reg_index))
				REG_FRAME_WIDTH:  fw_q <= write_data;
				REG_FRAME_HEIGHT: fh_q <= write_data;
				default: ;
			endcase
		end
	end

	// A stalled result at the output freezes every stage.
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Frame sizes clamped to the supported range.
	logic [DIM_W-1:0] w_cl, h_cl;
	always_comb begin
		w_cl = (fw_q < DIM_W'(2)) ? DIM_W'(2) : ((int'(fw_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : fw_q);
		h_cl = (fh_q < DIM_W'(2)) ? DIM_W'(2) : ((int'(fh_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : fh_q);
	end

	// Stage 1: capture the beat, form width times the center factor.
	logic                 v_s1;
	logic [PIX_X_W-1:0]   x_s1;
	logic [PIX_Y_W-1:0]   y_s1;
	logic [DIM_W-1:0]     w_s1, h_s1;
	logic [WK_W-1:0]      wk_s1;
	logic [COL_W-1:0]     mir_s1;

	// Stage 2: lens center and offsets as sign and magnitude.
	logic                 v_s2;
	geo_t                 g_s2;
	geo_t                 g_c2;
	logic [CW-1:0]        xq_c2, yq_c2;

	// Stages 3 to 5: squares, squared radius, saturation and divider setup.
	logic                 v_s3, v_s4, v_s5;
	geo_t                 g_s3, g_s4;
	logic [SQ_W-1:0]      sqx_s3, sqy_s3, den_s3, den_s4, den_s5, rem_s5;
	logic [NUM_W-1:0]     num_s4;
	logic [DD_Q-1:0]      fb_s5;
	ddside_t              dds_s5;

	always_comb begin
		xq_c2       = CW'({x_s1, 16'b0});
		yq_c2       = {y_s1, 16'b0};
		g_c2.xs.cx  = CW'((wk_s1 + WK_W'(32768)) >> 16);
		g_c2.ys.cy  = {h_s1, 15'b0};
		g_c2.xs.w   = w_s1;
		g_c2.ys.h   = h_s1;
		g_c2.xs.mirror = mir_s1;
		g_c2.xs.xneg = (xq_c2 < g_c2.xs.cx);
		g_c2.ys.yneg = (yq_c2 < g_c2.ys.cy);
		g_c2.dxm = g_c2.xs.xneg ? (g_c2.xs.cx - xq_c2) : (xq_c2 - g_c2.xs.cx);
		g_c2.dym = g_c2.ys.yneg ? (g_c2.ys.cy - yq_c2) : (yq_c2 - g_c2.ys.cy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= pixel_x;
			y_s1   <= pixel_y;
			w_s1   <= w_cl;
			h_s1   <= h_cl;
			wk_s1  <= WK_W'(w_cl) * WK_W'(K_Q32);
			mir_s1 <= COL_W'(w_cl - DIM_W'(pixel_x) - DIM_W'(1));
			g_s2   <= g_c2;
			sqx_s3 <= g_s2.dxm * g_s2.dxm;
			sqy_s3 <= g_s2.dym * g_s2.dym;
			den_s3 <= g_s2.xs.cx * g_s2.xs.cx;
			g_s3   <= g_s2;
			num_s4 <= NUM_W'(sqx_s3) + NUM_W'(sqy_s3);
			den_s4 <= den_s3;
			g_s4   <= g_s3;
			dds_s5.g   <= g_s4;
			dds_s5.sat <= (num_s4 >= {den_s4, 11'b0});
			rem_s5 <= SQ_W'(num_s4 >> DD_INT);
			fb_s5  <= {num_s4[DD_INT-1:0], 24'b0};
			den_s5 <= den_s4;
		end
	end

	// Normalized squared radius dd in Q24.
	logic            v_dd;
	logic [DD_Q-1:0] q_dd;
	ddside_t         dds_o;
	logic [DD_W-1:0] dd_c;
	polyside_t       ps_in;

	rld_div #(.DW(SQ_W), .QN(DD_Q), .SW($bits(ddside_t))) u_div_dd (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.v_in   (v_s5),
		.r_in   (rem_s5),
		.fb_in  (fb_s5),
		.d_in   (den_s5),
		.sb_in  (dds_s5),
		.v_out  (v_dd),
		.q_out  (q_dd),
		.sb_out (dds_o)
	);

	assign dd_c     = dds_o.sat ? DD_SAT : {1'b0, q_dd};
	assign ps_in.g  = dds_o.g;
	assign ps_in.dd = dd_c;

	// Horner evaluation of the distortion polynomial, one multiply-add per step.
	logic                   v_p1, v_p2, v_p3;
	logic [C3_W+DD_W-1:0]   p1;
	logic [A_W+DD_W-1:0]    p2;
	logic [B_W+DD_W-1:0]    p3;
	polyside_t              ps1, ps2, ps3;
	logic [A_W-1:0]         a_val;
	logic [B_W-1:0]         b_val;
	logic [DQ_W-1:0]        dq_val;

	rld_mul #(.AW(C3_W), .BW(DD_W), .SW($bits(polyside_t))) u_mul_a (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.v_in   (v_dd),
		.a      (COEF3_Q24),
		.b      (dd_c),
		.c      ((C3_W+DD_W)'(COEF2_Q24) << DD_FRAC),
		.sb_in  (ps_in),
		.v_out  (v_p1),
		.p      (p1),
		.sb_out (ps1)
	);

	assign a_val = p1[A_W+DD_FRAC-1:DD_FRAC];

	rld_mul #(.AW(A_W), .BW(DD_W), .SW($bits(polyside_t))) u_mul_b (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.v_in   (v_p1),
		.a      (a_val),
		.b      (ps1.dd),
		.c      ((A_W+DD_W)'(COEF1_Q24) << DD_FRAC),
		.sb_in  (ps1),
		.v_out  (v_p2),
		.p      (p2),
		.sb_out (ps2)
	);

	assign b_val = p2[B_W+DD_FRAC-1:DD_FRAC];

	rld_mul #(.AW(B_W), .BW(DD_W), .SW($bits(polyside_t))) u_mul_d (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.v_in   (v_p2),
		.a      (b_val),
		.b      (ps2.dd),
		.c      ((B_W+DD_W)'(1) << (2 * DD_FRAC)),
		.sb_in  (ps2),
		.v_out  (v_p3),
		.p      (p3),
		.sb_out (ps3)
	);

	assign dq_val = p3[DQ_W+DD_FRAC-1:DD_FRAC];

	// Offsets scaled by the polynomial, with rounding half up added in.
	logic             v_sx, v_sy;
	logic [PSC_W-1:0] psx, psy;
	xside_t           xs_o;
	yside_t           ys_o;

	rld_mul #(.AW(CW), .BW(DQ_W), .SW($bits(xside_t))) u_mul_sx (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.v_in   (v_p3),
		.a      (ps3.g.dxm),
		.b      (dq_val),
		.c      (PSC_W'(1) << 23),
		.sb_in  (ps3.g.xs),
		.v_out  (v_sx),
		.p      (psx),
		.sb_out (xs_o)
	);

	rld_mul #(.AW(CW), .BW(DQ_W), .SW($bits(yside_t))) u_mul_sy (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.v_in   (v_p3),
		.a      (ps3.g.dym),
		.b      (dq_val),
		.c      (PSC_W'(1) << 23),
		.sb_in  (ps3.g.ys),
		.v_out  (v_sy),
		.p      (psy),
		.sb_out (ys_o)
	);

	// Stage 49: saturate the scaled offsets. Stage 50: remapped positions.
	// Stage 51: texture numerators. Stage 52: clamp detection and divider setup.
	logic                      v_s49, v_s50, v_s51, v_s52;
	logic [OFF_W-1:0]          offx_s49, offy_s49;
	xside_t                    xs_s49;
	yside_t                    ys_s49;
	logic signed [TPOS_W-1:0]  tu_s50, tv_s50;
	logic [DIM_W-1:0]          w_s50, h_s50;
	logic [COL_W-1:0]          mir_s50, mir_s51;
	logic                      zu_s51, zv_s51;
	logic [NT_W-1:0]           ntu_s51, ntv_s51;
	logic [TD_W-1:0]           denu_s51, denv_s51, denu_s52, denv_s52;
	logic [TD_W-1:0]           remu_s52, remv_s52;
	logic [QT-1:0]             fbu_s52, fbv_s52;
	uside_t                    us_s52;
	vside_t                    vs_s52;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s49 <= 1'b0;
			v_s50 <= 1'b0;
			v_s51 <= 1'b0;
			v_s52 <= 1'b0;
		end else if (adv) begin
			v_s49 <= v_sx && v_sy;
			v_s50 <= v_s49;
			v_s51 <= v_s50;
			v_s52 <= v_s51;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			offx_s49 <= (psx > SC_LIM) ? OFF_SAT : psx[OFF_W+23:24];
			offy_s49 <= (psy > SC_LIM) ? OFF_SAT : psy[OFF_W+23:24];
			xs_s49   <= xs_o;
			ys_s49   <= ys_o;

			tu_s50  <= xs_s49.xneg ? (TPOS_W'(xs_s49.cx) - TPOS_W'(offx_s49))
				: (TPOS_W'(xs_s49.cx) + TPOS_W'(offx_s49));
			tv_s50  <= ys_s49.yneg ? (TPOS_W'(ys_s49.cy) - TPOS_W'(offy_s49))
				: (TPOS_W'(ys_s49.cy) + TPOS_W'(offy_s49));
			w_s50   <= xs_s49.w;
			h_s50   <= ys_s49.h;
			mir_s50 <= xs_s49.mirror;

			zu_s51   <= (tu_s50 <= 0);
			zv_s51   <= (tv_s50 <= 0);
			ntu_s51  <= (NT_W'(tu_s50[POS_W-1:0]) << F) + (NT_W'(w_s50) << 15);
			ntv_s51  <= (NT_W'(tv_s50[POS_W-1:0]) << F) + (NT_W'(h_s50) << 15);
			denu_s51 <= {w_s50, 16'b0};
			denv_s51 <= {h_s50, 16'b0};
			mir_s51  <= mir_s50;

			us_s52.zero   <= zu_s51;
			us_s52.sat    <= (ntu_s51 >= ((NT_W'(denu_s51) << (F - 1)) + NT_W'(denu_s51)));
			us_s52.mirror <= mir_s51;
			vs_s52.zero   <= zv_s51;
			vs_s52.sat    <= (ntv_s51 >= ((NT_W'(denv_s51) << F) + NT_W'(denv_s51)));
			remu_s52 <= TD_W'(ntu_s51 >> QT);
			remv_s52 <= TD_W'(ntv_s51 >> QT);
			fbu_s52  <= ntu_s51[QT-1:0];
			fbv_s52  <= ntv_s51[QT-1:0];
			denu_s52 <= denu_s51;
			denv_s52 <= denv_s51;
		end
	end

	// Division by the frame size gives u and v.
	logic          v_du, v_dv;
	logic [QT-1:0] q_u, q_v;
	uside_t        us_o;
	vside_t        vs_o;

	rld_div #(.DW(TD_W), .QN(QT), .SW($bits(uside_t))) u_div_u (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.v_in   (v_s52),
		.r_in   (remu_s52),
		.fb_in  (fbu_s52),
		.d_in   (denu_s52),
		.sb_in  (us_s52),
		.v_out  (v_du),
		.q_out  (q_u),
		.sb_out (us_o)
	);

	rld_div #(.DW(TD_W), .QN(QT), .SW($bits(vside_t))) u_div_v (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.v_in   (v_s52),
		.r_in   (remv_s52),
		.fb_in  (fbv_s52),
		.d_in   (denv_s52),
		.sb_in  (vs_s52),
		.v_out  (v_dv),
		.q_out  (q_v),
		.sb_out (vs_o)
	);

	// Output register: clamp, mirror the right eye, hold while stalled.
	logic [F-1:0] left_c;
	logic         vo_sn;
	logic [F-1:0] lu_sn;
	logic [F:0]   ru_sn, tv_sn;
	logic [COL_W-1:0] mc_sn;

	always_comb begin
		if (us_o.zero) begin
			left_c = '0;
		end else if (us_o.sat) begin
			left_c = F'(1) << (F - 1);
		end else begin
			left_c = q_u[F-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_sn <= 1'b0;
		end else if (adv) begin
			vo_sn <= v_du && v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lu_sn <= left_c;
			ru_sn <= ((F + 1)'(1) << F) - {1'b0, left_c};
			tv_sn <= vs_o.zero ? '0 : (vs_o.sat ? ((F + 1)'(1) << F) : q_v);
			mc_sn <= us_o.mirror;
		end
	end

	assign out_valid     = vo_sn;
	assign left_tex_u    = lu_sn;
	assign right_tex_u   = ru_sn;
	assign tex_v         = tv_sn;
	assign mirror_column = mc_sn;

endmodule

// ----- rtl/rld_checker.sv -----
// Port-level checks for the radial lens distortion remap block.
// Depends on rld_pkg and is bound to radial_lens_distortion_map_core below.
module rld_checker
	import rld_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [FRAC_BITS-1:0] left_tex_u,
	input logic [FRAC_BITS:0]   right_tex_u,
	input logic [FRAC_BITS:0]   tex_v,
	input logic [COL_W-1:0]     mirror_column
);

	localparam int SW = FRAC_BITS + 2;
	localparam logic [SW-1:0]        ONE_E  = SW'(1) << FRAC_BITS;
	localparam logic [FRAC_BITS-1:0] HALF   = FRAC_BITS'(1) << (FRAC_BITS - 1);
	localparam logic [FRAC_BITS:0]   ONE_V  = (FRAC_BITS + 1)'(1) << FRAC_BITS;

	// A waiting result beat stays on the port.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(left_tex_u) && $stable(tex_v)
			&& $stable(mirror_column))
		else $error("result payload changed while stalled");

	// The two eyes' u values always sum to one.
	a_mirror_u: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (SW'(left_tex_u) + SW'(right_tex_u)) == ONE_E)
		else $error("right eye u is not one minus left eye u");

	// Clamped ranges of u and v.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (left_tex_u <= HALF) && (tex_v <= ONE_V))
		else $error("texture coordinate outside its clamp");

	// The input side stalls only behind a stalled result.
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with no result waiting");

endmodule

bind radial_lens_distortion_map_core rld_checker #(.FRAC_BITS(FRAC_BITS)) u_rld_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.left_tex_u    (left_tex_u),
	.right_tex_u   (right_tex_u),
	.tex_v         (tex_v),
	.mirror_column (mirror_column)
);
